>>> sv/oale_pkg.sv
// Shared constants, codes and word types for the ordered array list engine.
package oale_pkg;

   localparam int CAPACITY = 64;
   localparam int AW       = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int FOUND_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int DATA_W   = 32;
   localparam int XW       = ((CW > POS_W) ? CW : POS_W) + 2;

   typedef enum logic [2:0] {
      KIND_APPEND     = 3'd0,
      KIND_INSERT     = 3'd1,
      KIND_DELETE     = 3'd2,
      KIND_SEARCH     = 3'd3,
      KIND_TRANSPOSE  = 3'd4,
      KIND_MOVE_FRONT = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_MISS   = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [FOUND_W-1:0]       found_position;
      logic signed [DATA_W-1:0] removed_value;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_CNT, IDX_POS, IDX_ZERO, IDX_INC, IDX_DEC
   } idx_op_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_VAL_IDX, WR_RD_IDX, WR_KEY_IDXM1, WR_KEY_ZERO
   } wr_op_type;

   typedef enum logic [2:0] {
      RD_NONE, RD_POS, RD_ZERO, RD_IDXM1, RD_IDXM2, RD_IDXP1, RD_IDXP2
   } rd_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD, CNT_INC, CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      FOUND_ZERO, FOUND_IDX, FOUND_IDXM1
   } found_sel_type;

   typedef struct packed {
      logic          load;
      idx_op_type    idx_op;
      wr_op_type     wr_op;
      rd_op_type     rd_op;
      cnt_op_type    cnt_op;
      logic          cap_removed;
      logic          rsp_valid;
      status_type    rsp_status;
      found_sel_type found_sel;
      logic          rsp_removed;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       full;
      logic       cnt_zero;
      logic       pos_gt_cnt;
      logic       pos_ge_cnt;
      logic       idx_eq_pos;
      logic       idxm1_eq_pos;
      logic       idx_zero;
      logic       idxp1_lt_cnt;
      logic       idxp2_lt_cnt;
      logic       hit;
   } dp_stat_type;

endpackage

>>> sv/oale_datapath.sv
// Datapath: entry memory, count, walk index, read register and result word.
module oale_datapath (
   input  logic               clock,
   input  logic               reset,
   input  oale_pkg::req_type  req_word,
   input  oale_pkg::dp_cmd_type cmd,
   output oale_pkg::dp_stat_type stat,
   output logic               rsp_valid,
   output oale_pkg::rsp_type  rsp_word
);
   import oale_pkg::*;

   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [DATA_W-1:0] entry_mem_ff [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;
   logic [DATA_W-1:0] removed_ff, removed_in;
   req_type           req_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]     idx_m1, idx_m2, idx_p1, idx_p2;
   logic [XW-1:0]     idx_x, cnt_x, pos_x;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data;

   assign idx_m1 = idx_ff - CW'(1);
   assign idx_m2 = idx_ff - CW'(2);
   assign idx_p1 = idx_ff + CW'(1);
   assign idx_p2 = idx_ff + CW'(2);
   assign idx_x  = XW'(idx_ff);
   assign cnt_x  = XW'(cnt_ff);
   assign pos_x  = XW'(req_ff.position);

   // status toward the controller
   always_comb begin
      stat.kind         = req_ff.kind;
      stat.full         = (cnt_ff == CAP_C);
      stat.cnt_zero     = (cnt_ff == '0);
      stat.pos_gt_cnt   = (pos_x > cnt_x);
      stat.pos_ge_cnt   = (pos_x >= cnt_x);
      stat.idx_eq_pos   = (idx_x == pos_x);
      stat.idxm1_eq_pos = (idx_x - XW'(1) == pos_x);
      stat.idx_zero     = (idx_ff == '0);
      stat.idxp1_lt_cnt = (idx_x + XW'(1) < cnt_x);
      stat.idxp2_lt_cnt = (idx_x + XW'(2) < cnt_x);
      stat.hit          = (rdata_ff == req_ff.key);
   end

   // memory port selection
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rdata_ff;
      case (cmd.wr_op)
         WR_NONE:      wr_en = 1'b0;
         WR_VAL_IDX:   wr_data = req_ff.value;
         WR_RD_IDX:    wr_data = rdata_ff;
         WR_KEY_IDXM1: begin
            wr_addr = idx_m1[AW-1:0];
            wr_data = req_ff.key;
         end
         WR_KEY_ZERO: begin
            wr_addr = '0;
            wr_data = req_ff.key;
         end
         default:      wr_en = 1'b0;
      endcase
   end

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = idx_ff[AW-1:0];
      case (cmd.rd_op)
         RD_NONE:  rd_en = 1'b0;
         RD_POS:   rd_addr = AW'(req_ff.position);
         RD_ZERO:  rd_addr = '0;
         RD_IDXM1: rd_addr = idx_m1[AW-1:0];
         RD_IDXM2: rd_addr = idx_m2[AW-1:0];
         RD_IDXP1: rd_addr = idx_p1[AW-1:0];
         RD_IDXP2: rd_addr = idx_p2[AW-1:0];
         default:  rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= entry_mem_ff[rd_addr];
      end
   end

   // index, count, result
   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_CNT:  idx_in = cnt_ff;
         IDX_POS:  idx_in = CW'(req_ff.position);
         IDX_ZERO: idx_in = '0;
         IDX_INC:  idx_in = idx_p1;
         IDX_DEC:  idx_in = idx_m1;
         default:  idx_in = idx_ff;
      endcase

      case (cmd.cnt_op)
         CNT_HOLD: cnt_in = cnt_ff;
         CNT_INC:  cnt_in = cnt_ff + CW'(1);
         CNT_DEC:  cnt_in = cnt_ff - CW'(1);
         default:  cnt_in = cnt_ff;
      endcase

      removed_in = cmd.cap_removed ? rdata_ff : removed_ff;

      rsp_in.status        = cmd.rsp_status;
      rsp_in.removed_value = cmd.rsp_removed ? removed_in : '0;
      rsp_in.entry_count   = COUNT_W'(cnt_in);
      case (cmd.found_sel)
         FOUND_ZERO:  rsp_in.found_position = '0;
         FOUND_IDX:   rsp_in.found_position = FOUND_W'(idx_ff);
         FOUND_IDXM1: rsp_in.found_position = FOUND_W'(idx_m1);
         default:     rsp_in.found_position = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      idx_ff     <= idx_in;
      removed_ff <= removed_in;
      if (cmd.rsp_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.rsp_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> sv/oale_controller.sv
// Controller: sequences each operation over the datapath one memory step a cycle.
module oale_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  oale_pkg::dp_stat_type stat,
   output oale_pkg::dp_cmd_type  cmd,
   output logic                  busy
);
   import oale_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECODE   = 8'b0000_0010,
      S_SHIFT_UP = 8'b0000_0100,
      S_FILL     = 8'b0000_1000,
      S_CAPTURE  = 8'b0001_0000,
      S_SHIFT_DN = 8'b0010_0000,
      S_SCAN     = 8'b0100_0000,
      S_SWAP     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.idx_op      = IDX_HOLD;
      cmd.wr_op       = WR_NONE;
      cmd.rd_op       = RD_NONE;
      cmd.cnt_op      = CNT_HOLD;
      cmd.cap_removed = 1'b0;
      cmd.rsp_valid   = 1'b0;
      cmd.rsp_status  = ST_OK;
      cmd.found_sel   = FOUND_ZERO;
      cmd.rsp_removed = 1'b0;

      case (state_ff)
         S_IDLE: begin
            cmd.idx_op = IDX_CNT;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_IDLE;
            case (stat.kind)
               KIND_APPEND: begin
                  cmd.rsp_valid = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.wr_op  = WR_VAL_IDX;
                     cmd.cnt_op = CNT_INC;
                  end
               end
               KIND_INSERT: begin
                  if (stat.full) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end else if (stat.pos_gt_cnt) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else if (stat.idx_eq_pos) begin
                     cmd.rsp_valid = 1'b1;
                     cmd.wr_op     = WR_VAL_IDX;
                     cmd.cnt_op    = CNT_INC;
                  end else begin
                     cmd.rd_op = RD_IDXM1;
                     state_in  = S_SHIFT_UP;
                  end
               end
               KIND_DELETE: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else begin
                     cmd.idx_op = IDX_POS;
                     cmd.rd_op  = RD_POS;
                     state_in   = S_CAPTURE;
                  end
               end
               KIND_SEARCH, KIND_TRANSPOSE, KIND_MOVE_FRONT: begin
                  if (stat.cnt_zero) begin
                     cmd.rsp_valid  = 1'b1;
                     cmd.rsp_status = ST_MISS;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     cmd.rd_op  = RD_ZERO;
                     state_in   = S_SCAN;
                  end
               end
               default: cmd.rsp_valid = 1'b1;
            endcase
         end

         // move entry idx-1 up to idx, walking down toward the insert point
         S_SHIFT_UP: begin
            cmd.wr_op  = WR_RD_IDX;
            cmd.idx_op = IDX_DEC;
            if (stat.idxm1_eq_pos) begin
               state_in = S_FILL;
            end else begin
               cmd.rd_op = RD_IDXM2;
            end
         end

         S_FILL: begin
            cmd.wr_op     = WR_VAL_IDX;
            cmd.cnt_op    = CNT_INC;
            cmd.rsp_valid = 1'b1;
            state_in      = S_IDLE;
         end

         S_CAPTURE: begin
            cmd.cap_removed = 1'b1;
            if (stat.idxp1_lt_cnt) begin
               cmd.rd_op = RD_IDXP1;
               state_in  = S_SHIFT_DN;
            end else begin
               cmd.cnt_op      = CNT_DEC;
               cmd.rsp_valid   = 1'b1;
               cmd.rsp_removed = 1'b1;
               state_in        = S_IDLE;
            end
         end

         // move entry idx+1 down to idx
         S_SHIFT_DN: begin
            cmd.wr_op = WR_RD_IDX;
            if (stat.idxp2_lt_cnt) begin
               cmd.rd_op  = RD_IDXP2;
               cmd.idx_op = IDX_INC;
            end else begin
               cmd.cnt_op      = CNT_DEC;
               cmd.rsp_valid   = 1'b1;
               cmd.rsp_removed = 1'b1;
               state_in        = S_IDLE;
            end
         end

         // read data holds entry idx; the next read is issued alongside the compare
         S_SCAN: begin
            if (stat.hit) begin
               case (stat.kind)
                  KIND_TRANSPOSE: begin
                     if (stat.idx_zero) begin
                        cmd.rsp_valid = 1'b1;
                        cmd.found_sel = FOUND_ZERO;
                        state_in      = S_IDLE;
                     end else begin
                        cmd.wr_op = WR_KEY_IDXM1;
                        cmd.rd_op = RD_IDXM1;
                        state_in  = S_SWAP;
                     end
                  end
                  KIND_MOVE_FRONT: begin
                     cmd.wr_op = WR_KEY_ZERO;
                     cmd.rd_op = RD_ZERO;
                     state_in  = S_SWAP;
                  end
                  default: begin
                     cmd.rsp_valid = 1'b1;
                     cmd.found_sel = FOUND_IDX;
                     state_in      = S_IDLE;
                  end
               endcase
            end else if (stat.idxp1_lt_cnt) begin
               cmd.rd_op  = RD_IDXP1;
               cmd.idx_op = IDX_INC;
            end else begin
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_status = ST_MISS;
               state_in       = S_IDLE;
            end
         end

         // old partner entry goes to where the key was found
         S_SWAP: begin
            cmd.wr_op     = WR_RD_IDX;
            cmd.rsp_valid = 1'b1;
            cmd.found_sel = (stat.kind == KIND_TRANSPOSE) ? FOUND_IDXM1 : FOUND_ZERO;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> sv/ordered_array_list_engine.sv
// Top level of the ordered array list engine: controller plus datapath.
//
// Keeps an ordered list of up to CAPACITY (64) signed 32-bit entries and a count.
// Request channel: drive req_word and raise start; the word is taken at a clock
// edge where start is high and busy is low. busy stays high until the result
// has been produced; one word is worked on at a time.
// Kinds: append, insert at a position, delete at a position, and three linear
// searches (plain, transpose toward the front, move-to-front by swap with entry 0).
// Result channel: rsp_valid is high for exactly one cycle with rsp_word; the
// receiver cannot stall, so it must take the word in that cycle. Exactly one
// result word per request word. busy is already low while rsp_valid is high.
// Append, insert at the count, errors, empty-list searches and unused kinds end in
// decode. Other inserts move entries from the count down to the position up one,
// a delete moves those above the position down one, a search scans from entry 0
// to a hit or the end, and a hit swaps for move-to-front (and transpose unless at 0).
// The memory has one write and one registered read port, so each shifted or scanned
// entry is its own step. A new word may start in the result cycle.
// Reset (synchronous, active high) empties the list; entry storage is not
// cleared, since only entries below the count are ever read.
module ordered_array_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oale_pkg::req_type req_word,
   output logic              rsp_valid,
   output oale_pkg::rsp_type rsp_word
);
   import oale_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: one memory step per cycle
   oale_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // entry memory, count, index and result register
   oale_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

>>> sv/oale_checker.sv
// Port-level checker for the ordered array list engine, bound to the top level.
module oale_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input oale_pkg::rsp_type rsp_word
);
   import oale_pkg::*;

   // a result word only appears once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while busy");

   // an accepted word keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   // finishing a word always produces its result
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result word");

   // no two result words back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_MISS) |-> (rsp_word.found_position == '0))
      else $error("miss with nonzero found position");

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
